// ----- sv/kms_pkg.sv -----
// Package for the keypad matrix scanner: geometry constants, codes and word types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package kms_pkg;
  localparam int MaxRows = 8;
  localparam int MaxCols = 15;
  localparam int KeySlots = MaxRows * MaxCols;
  localparam int RingDepth = 16;
  localparam int TimeWidth = 16;
  localparam int KeyIdxW = $clog2(KeySlots);
  localparam int RingPtrW = $clog2(RingDepth);

  localparam logic [2:0] OP_SCAN = 3'd0;
  localparam logic [2:0] OP_READ = 3'd1;
  localparam logic [2:0] OP_READ_PRESS = 3'd2;
  localparam logic [2:0] OP_FLUSH = 3'd3;
  localparam logic [2:0] OP_PUSH_BACK = 3'd4;
  localparam logic [2:0] OP_QUERY = 3'd5;

  localparam logic [2:0] REG_ROWS = 3'd0;
  localparam logic [2:0] REG_COLS = 3'd1;
  localparam logic [2:0] REG_FIRST_DELAY = 3'd2;
  localparam logic [2:0] REG_INTERVAL = 3'd3;
  localparam logic [2:0] REG_RELEASE_HOLD = 3'd4;

  typedef struct packed {
    logic [2:0] opcode;
    logic [3:0] column_index;
    logic [7:0] row_pressed;
    logic [15:0] time_ms;
    logic [7:0] key_code;
  } in_word_t;

  typedef struct packed {
    logic [7:0] key_out;
    logic key_is_pressed;
    logic no_key_pressed;
    logic [3:0] events_queued;
    logic [3:0] events_dropped;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ROW_READ, ST_ROW_EXEC, ST_READ, ST_COUNT, ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic row_read;
    logic row_exec;
    logic row_next;
    logic read_pop;
    logic op_simple;
    logic count_clear;
    logic count_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic rows_done;
    logic read_again;
    logic count_done;
  } status_t;
endpackage

// ----- sv/keypad_matrix_scanner.sv -----
// Top level of the keypad matrix scanner.
// Depends on kms_pkg, kms_ctrl and kms_datapath.
//
// Usage: drive in_word and raise start while busy is low; the word is taken at
// that edge and busy rises. Configuration writes go through cfg_valid/cfg_ready
// with a register index and data. The user must write only while the block is idle; the block does not enforce it.
// Each command produces one result word, shown on out_word for one cycle with
// out_valid high. The receiver cannot stall; results are never held back.
// Sequence after the accepting edge: a scan passes ST_ROW_READ and ST_ROW_EXEC
// for each scanned row and then a final ST_ROW_READ, a read one ST_READ per
// popped word, any other command ST_COUNT; then ST_DONE walks the held flags
// one key per cycle (rows times cols keys, at least one). The result shows in
// the following cycle with busy already low, so the next word can be taken at
// the edge that ends it. One command is in flight at a time.
// After synchronous reset the registers hold their defaults, no key is held,
// the event ring and push-back slot are empty.
// The per-key timestamps are undefined until first written by a press.
`timescale 1ns / 1ps
module keypad_matrix_scanner (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  kms_pkg::in_word_t in_word,
  output logic out_valid,
  output kms_pkg::out_word_t out_word,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data
);
  kms_pkg::cmd_t cmd;
  kms_pkg::status_t status;
  kms_pkg::out_word_t dp_word;
  logic out_valid_r;

  assign cfg_ready = 1'b1;

  kms_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .opcode(in_word.opcode),
    .status(status), .cmd(cmd), .busy(busy)
  );

  kms_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .in_word(in_word),
    .cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd), .status(status), .out_word(dp_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= cmd.emit;
  end

  assign out_valid = out_valid_r;
  assign out_word = dp_word;

  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !$past(start && !busy))
    else $error("result one cycle after accept");
  assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
    else $error("busy did not rise after accept");
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !busy)
    else $error("result shown while busy");
endmodule

// ----- sv/kms_datapath.sv -----
// Datapath of the keypad matrix scanner: key state stores, event ring, configuration.
// Depends on kms_pkg; driven by kms_ctrl.
`timescale 1ns / 1ps
module kms_datapath (
  input  logic clk,
  input  logic rst_n,
  input  kms_pkg::in_word_t in_word,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data,
  input  kms_pkg::cmd_t cmd,
  output kms_pkg::status_t status,
  output kms_pkg::out_word_t out_word
);
  localparam int KW = kms_pkg::KeyIdxW;
  localparam int PW = kms_pkg::RingPtrW;
  localparam int TW = kms_pkg::TimeWidth;

  logic [3:0] rows_r, cols_r;
  logic [14:0] first_r, intv_r, hold_r;
  logic [kms_pkg::KeySlots-1:0] held_r;
  logic [TW-1:0] rep_mem [kms_pkg::KeySlots];
  logic [TW-1:0] rel_mem [kms_pkg::KeySlots];
  logic [7:0] ring_mem [kms_pkg::RingDepth];
  logic [PW-1:0] wp_r, rp_r;
  logic [7:0] slot_r;
  kms_pkg::in_word_t w_r;
  logic [3:0] row_r;
  logic [KW-1:0] idx_r;
  logic [TW-1:0] rep_q_r, rel_q_r;
  logic [3:0] lost_r;
  logic [7:0] key_r;
  logic pressed_r;
  logic [KW-1:0] cnt_r;
  logic any_r;
  logic [3:0] er, ec;
  logic [7:0] nkeys;
  logic [TW-1:0] d_rep, d_rel;
  logic fire_rep, fire_rel, bit_on, held_i, push, full, ring_empty;
  logic [7:0] push_code, pop_code;
  logic [6:0] qk;

  always_comb begin
    er = (rows_r > 4'(kms_pkg::MaxRows)) ? 4'(kms_pkg::MaxRows) : rows_r;
    ec = (cols_r > 4'(kms_pkg::MaxCols)) ? 4'(kms_pkg::MaxCols) : cols_r;
    nkeys = {4'd0, er} * {4'd0, ec};
    d_rep = w_r.time_ms - rep_q_r;
    d_rel = w_r.time_ms - rel_q_r;
    fire_rep = !d_rep[TW-1] && (d_rep >= TW'(intv_r));
    fire_rel = !d_rel[TW-1] && (d_rel >= TW'(hold_r));
    bit_on = w_r.row_pressed[row_r[2:0]];
    held_i = held_r[idx_r];
    full = (wp_r + PW'(1)) == rp_r;
    ring_empty = wp_r == rp_r;
    push = 1'b0;
    push_code = 8'(idx_r) + 8'd1;
    if (bit_on) begin
      push = !held_i || fire_rep;
    end else if (held_i && fire_rel) begin
      push = 1'b1;
      push_code = push_code | 8'h80;
    end
    pop_code = (slot_r != 8'd0) ? slot_r : (ring_empty ? 8'd0 : ring_mem[rp_r]);
    status.rows_done = (row_r >= er) || (w_r.column_index >= ec);
    status.read_again = (w_r.opcode == kms_pkg::OP_READ_PRESS) && pop_code[7];
    status.count_done = (8'(cnt_r) + 8'd1) >= nkeys;
    qk = w_r.key_code[6:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= 4'd4; cols_r <= 4'd4;
      first_r <= 15'd400; intv_r <= 15'd100; hold_r <= 15'd50;
      held_r <= '0; wp_r <= '0; rp_r <= '0; slot_r <= 8'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          kms_pkg::REG_ROWS: rows_r <= cfg_data[3:0];
          kms_pkg::REG_COLS: cols_r <= cfg_data[3:0];
          kms_pkg::REG_FIRST_DELAY: first_r <= cfg_data[14:0];
          kms_pkg::REG_INTERVAL: intv_r <= cfg_data[14:0];
          kms_pkg::REG_RELEASE_HOLD: hold_r <= cfg_data[14:0];
          default: ;
        endcase
      end
      if (cmd.row_exec) begin
        if (bit_on) held_r[idx_r] <= 1'b1;
        else if (held_i && fire_rel) held_r[idx_r] <= 1'b0;
        if (push && !full) wp_r <= wp_r + PW'(1);
      end
      if (cmd.read_pop) begin
        if (slot_r != 8'd0) slot_r <= 8'd0;
        else if (!ring_empty) rp_r <= rp_r + PW'(1);
      end
      if (cmd.op_simple) begin
        if (w_r.opcode == kms_pkg::OP_FLUSH) begin
          rp_r <= wp_r; slot_r <= 8'd0;
        end else if (w_r.opcode == kms_pkg::OP_PUSH_BACK) begin
          slot_r <= w_r.key_code;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w_r <= in_word;
      row_r <= 4'd0;
      idx_r <= KW'(in_word.column_index);
      lost_r <= 4'd0;
      key_r <= 8'd0;
      pressed_r <= 1'b0;
    end
    if (cmd.row_read) begin
      rep_q_r <= rep_mem[idx_r];
      rel_q_r <= rel_mem[idx_r];
    end
    if (cmd.row_exec) begin
      if (bit_on) begin
        rel_mem[idx_r] <= w_r.time_ms;
        if (!held_i) rep_mem[idx_r] <= w_r.time_ms + TW'(first_r) - TW'(intv_r);
        else if (fire_rep) rep_mem[idx_r] <= w_r.time_ms;
      end
      if (push) begin
        if (full) lost_r <= lost_r + 4'd1;
        else ring_mem[wp_r] <= push_code;
      end
    end
    if (cmd.row_next) begin
      row_r <= row_r + 4'd1;
      idx_r <= idx_r + KW'(ec);
    end
    if (cmd.read_pop) key_r <= pop_code;
    if (cmd.op_simple && w_r.opcode == kms_pkg::OP_QUERY) begin
      pressed_r <= (qk != 7'd0) && (8'(qk) <= nkeys) && held_r[KW'(qk - 7'd1)];
    end
    if (cmd.count_clear) begin
      cnt_r <= '0;
      any_r <= 1'b0;
    end
    if (cmd.count_step) begin
      if (nkeys != 8'd0) any_r <= any_r | held_r[cnt_r];
      cnt_r <= cnt_r + KW'(1);
    end
  end

  always_comb begin
    out_word.key_out = key_r;
    out_word.key_is_pressed = pressed_r;
    out_word.no_key_pressed = !any_r;
    out_word.events_queued = 4'(wp_r - rp_r);
    out_word.events_dropped = lost_r;
  end
endmodule

// ----- sv/kms_ctrl.sv -----
// Controller of the keypad matrix scanner: sequences rows, reads and the held-key count.
// Depends on kms_pkg; drives kms_datapath.
`timescale 1ns / 1ps
module kms_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic [2:0] opcode,
  input  kms_pkg::status_t status,
  output kms_pkg::cmd_t cmd,
  output logic busy
);
  kms_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= kms_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = 1'b1;
    case (state_r)
      kms_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          case (opcode)
            kms_pkg::OP_SCAN: state_nxt = kms_pkg::ST_ROW_READ;
            kms_pkg::OP_READ, kms_pkg::OP_READ_PRESS: state_nxt = kms_pkg::ST_READ;
            default: state_nxt = kms_pkg::ST_COUNT;
          endcase
        end
      end
      kms_pkg::ST_ROW_READ: begin
        if (status.rows_done) begin
          cmd.count_clear = 1'b1;
          state_nxt = kms_pkg::ST_DONE;
        end else begin
          cmd.row_read = 1'b1;
          state_nxt = kms_pkg::ST_ROW_EXEC;
        end
      end
      kms_pkg::ST_ROW_EXEC: begin
        cmd.row_exec = 1'b1;
        cmd.row_next = 1'b1;
        state_nxt = kms_pkg::ST_ROW_READ;
      end
      kms_pkg::ST_READ: begin
        cmd.read_pop = 1'b1;
        if (!status.read_again) begin
          cmd.count_clear = 1'b1;
          state_nxt = kms_pkg::ST_DONE;
        end
      end
      kms_pkg::ST_COUNT: begin
        cmd.op_simple = 1'b1;
        cmd.count_clear = 1'b1;
        state_nxt = kms_pkg::ST_DONE;
      end
      kms_pkg::ST_DONE: begin
        cmd.count_step = 1'b1;
        if (status.count_done) begin
          state_nxt = kms_pkg::ST_IDLE;
          cmd.emit = 1'b1;
        end
      end
      default: state_nxt = kms_pkg::ST_IDLE;
    endcase
  end
endmodule
